[rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue: opcodes, status codes,
// transaction layouts and the sizes of the back-word reduction tree.
// ----------------------------------------------------------------------------
package deq_pkg;

   // field widths of the stream transactions
   localparam int OPCODE_W    = 3;
   localparam int WORD_W      = 32;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // back-word tree: fan-in of each level and number of registered levels
   localparam int TREE_FANIN  = 16;
   localparam int TREE_STAGES = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5
   } deq_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } deq_status_type;

   // command broadcast to every cell
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
   } deq_cmd_type;

   // result transaction, data_out in the lowest bits
   typedef struct packed {
      logic           is_empty;
      deq_status_type status;
      logic [WORD_W-1:0] data_out;
   } deq_rsp_type;

endpackage

[rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue built as a chain of storage cells. The front
// entry always sits in cell 0; cells fill contiguously from there, and a
// registered OR tree gathers the word of the last occupied cell.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata fields (lowest bit up)
//  ---------+-----------+----------------------------------------------------
//  req_     | in        | opcode[2:0], data_in[34:3], zero pad[39:35]
//  rsp_     | out       | data_out[31:0], status[33:32], is_empty[34], pad
//
//  one transaction is taken per cycle while req_tready is high; a pop back
//  or peek back that directly follows a transaction that changed the
//  contents waits while the back-word tree (2 registered levels) catches up
//  with the cells; a result is registered in the output register, which
//  drives rsp_, or in the skid register while that one is still full;
//  the two keep req_ open while one result waits; req_tready drops when
//  both hold a result or a back read waits; synchronous reset empties the
//  queue (occupied bits and output valids); stored words are not cleared
// ----------------------------------------------------------------------------
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // opcode, data_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // data_out, status, is_empty
);

   // ---------------------------------------------------------------------
   // request fields
   // ---------------------------------------------------------------------
   deq_op_type            op;
   logic [WORD_W-1:0]     req_word;
   logic [63:0]           req_word_ext;
   logic [DATA_WIDTH-1:0] push_word;

   assign op           = deq_op_type'(req_tdata[OPCODE_W-1:0]);
   assign req_word     = req_tdata[OPCODE_W +: WORD_W];
   // pushed words are cut or zero-extended to the storage width
   assign req_word_ext = 64'(req_word);
   assign push_word    = req_word_ext[DATA_WIDTH-1:0];

   // ---------------------------------------------------------------------
   // cell chain
   // ---------------------------------------------------------------------
   deq_cmd_type           cmd;
   logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
   logic [DATA_WIDTH-1:0] left_data  [DEPTH];
   logic [DATA_WIDTH-1:0] right_data [DEPTH];
   logic [DATA_WIDTH-1:0] back_words [DEPTH];
   logic [DEPTH-1:0]      occ_vec;
   logic [DEPTH-1:0]      left_occ;
   logic [DEPTH-1:0]      right_occ;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      // neighbor wiring: cell 0 sees the incoming word on its left,
      // the last cell sees an empty slot on its right
      if (i == 0) begin : g_head
         assign left_data[i] = push_word;
         assign left_occ[i]  = 1'b1;
      end else begin : g_body
         assign left_data[i] = cell_data[i-1];
         assign left_occ[i]  = occ_vec[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data[i] = '0;
         assign right_occ[i]  = 1'b0;
      end else begin : g_inner
         assign right_data[i] = cell_data[i+1];
         assign right_occ[i]  = occ_vec[i+1];
      end

      deq_cell #(
         .DW (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .push_word  (push_word),
         .left_data  (left_data[i]),
         .left_occ   (left_occ[i]),
         .right_data (right_data[i]),
         .right_occ  (right_occ[i]),
         .data_out   (cell_data[i]),
         .occ_out    (occ_vec[i]),
         .back_word  (back_words[i])
      );
   end

   // ---------------------------------------------------------------------
   // back word gather
   // ---------------------------------------------------------------------
   logic [DATA_WIDTH-1:0] tree_word;

   deq_tree #(
      .N  (DEPTH),
      .DW (DATA_WIDTH)
   ) u_tree (
      .clock (clock),
      .leaf  (back_words),
      .root  (tree_word)
   );

   // ---------------------------------------------------------------------
   // handshake and operation decode
   // ---------------------------------------------------------------------
   deq_rsp_type rsp_ff, rsp_in;
   deq_rsp_type skid_ff, skid_in;
   deq_rsp_type result;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [1:0]  settle_ff, settle_in;
   logic        req_acc;
   logic        rsp_acc;
   logic        back_op;
   logic        empty;
   logic        full;
   logic        single;
   logic        changed;
   logic [DATA_WIDTH-1:0] rd_word;
   logic [63:0]           rd_ext;

   assign empty   = ~occ_vec[0];
   assign full    = occ_vec[DEPTH-1];
   assign single  = occ_vec[0] & ~occ_vec[1];
   assign back_op = (op == OP_POP_BACK) || (op == OP_PEEK_BACK);

   // back reads wait until the tree reflects the current cells
   assign req_tready = ~skid_valid_ff & ~(back_op && (settle_ff != 2'd0));
   assign req_acc    = req_tvalid & req_tready;
   assign rsp_acc    = rsp_valid_ff & rsp_tready;

   always_comb begin
      cmd             = '0;
      rd_word         = '0;
      result.status   = ST_OK;
      result.is_empty = empty;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) begin
               result.status = ST_OVER;
            end else begin
               cmd.push_front  = req_acc && (op == OP_PUSH_FRONT);
               cmd.push_back   = req_acc && (op == OP_PUSH_BACK);
               result.is_empty = 1'b0;
            end
         end
         OP_POP_FRONT, OP_PEEK_FRONT: begin
            if (empty) begin
               result.status = ST_UNDER;
            end else begin
               rd_word = cell_data[0];
               if (op == OP_POP_FRONT) begin
                  cmd.pop_front   = req_acc;
                  result.is_empty = single;
               end
            end
         end
         OP_POP_BACK, OP_PEEK_BACK: begin
            if (empty) begin
               result.status = ST_UNDER;
            end else begin
               rd_word = tree_word;
               if (op == OP_POP_BACK) begin
                  cmd.pop_back    = req_acc;
                  result.is_empty = single;
               end
            end
         end
         default: begin
            // unused opcodes leave the queue alone
         end
      endcase
      rd_ext          = 64'(rd_word);
      result.data_out = rd_ext[WORD_W-1:0];
   end

   assign changed = |cmd;

   // ---------------------------------------------------------------------
   // output register, skid register and tree settle count
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_acc) begin
         rsp_in        = skid_ff;
         rsp_valid_in  = skid_valid_ff;
         skid_valid_in = 1'b0;
      end
      if (req_acc) begin
         if (!rsp_valid_ff || rsp_acc) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_comb begin
      settle_in = settle_ff;
      if (req_acc && changed) begin
         settle_in = 2'(TREE_STAGES);
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         settle_ff     <= 2'd0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         settle_ff     <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_ff);

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // occupied cells always form one run starting at cell 0
   a_occ_contiguous : assert property (@(posedge clock) disable iff (reset)
      (occ_vec & (occ_vec + 1'b1)) == '0)
      else $error("occupied cells are not contiguous from the front");

   // a held skid result implies the output register is also full
   a_skid_order : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a result ahead of the output register");

   // a granted push adds exactly one entry
   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      (cmd.push_front || cmd.push_back) |=>
         $countones(occ_vec) == $past($countones(occ_vec)) + 1)
      else $error("push did not add exactly one entry");

   // a granted pop removes exactly one entry
   a_pop_shrinks : assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_front || cmd.pop_back) |=>
         $countones(occ_vec) + 1 == $past($countones(occ_vec)))
      else $error("pop did not remove exactly one entry");

endmodule

[rtl/deq_cell.sv]
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue chain: holds one word and an occupied bit,
// shifts with its neighbors on front operations and takes or drops the word
// at the tail on back operations.
// ----------------------------------------------------------------------------
module deq_cell
   import deq_pkg::*;
#(
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  deq_cmd_type   cmd,
   input  logic [DW-1:0] push_word,
   input  logic [DW-1:0] left_data,
   input  logic          left_occ,
   input  logic [DW-1:0] right_data,
   input  logic          right_occ,
   output logic [DW-1:0] data_out,
   output logic          occ_out,
   output logic [DW-1:0] back_word
);

   logic [DW-1:0] data_ff, data_in;
   logic          occ_ff, occ_in;
   logic          tail;

   // last occupied cell of the chain
   assign tail = occ_ff & ~right_occ;

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      if (cmd.push_front) begin
         data_in = left_data;
         occ_in  = left_occ;
      end else if (cmd.push_back) begin
         if (!occ_ff && left_occ) begin
            data_in = push_word;
            occ_in  = 1'b1;
         end
      end else if (cmd.pop_front) begin
         data_in = right_data;
         occ_in  = right_occ;
      end else if (cmd.pop_back) begin
         if (tail) begin
            occ_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out  = data_ff;
   assign occ_out   = occ_ff;
   assign back_word = tail ? data_ff : '0;

endmodule

[rtl/deq_tree.sv]
// ----------------------------------------------------------------------------
// deq_tree
// Registered OR tree that collects the tail word of the cell chain; only the
// tail cell drives a nonzero leaf, so the root is the back word.
// ----------------------------------------------------------------------------
module deq_tree
   import deq_pkg::*;
#(
   parameter int N  = 16,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic [DW-1:0] leaf [N],
   output logic [DW-1:0] root
);

   localparam int G   = TREE_FANIN;
   localparam int L1N = (N + G - 1) / G;
   localparam int L2N = (L1N + G - 1) / G;

   logic [DW-1:0] l1_in [L1N];
   logic [DW-1:0] l1_ff [L1N];
   logic [DW-1:0] l2_in [L2N];
   logic [DW-1:0] l2_ff [L2N];

   always_comb begin
      for (int j = 0; j < L1N; j++) begin
         l1_in[j] = '0;
         for (int k = 0; k < G; k++) begin
            if (j * G + k < N) begin
               l1_in[j] = l1_in[j] | leaf[j * G + k];
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < L2N; j++) begin
         l2_in[j] = '0;
         for (int k = 0; k < G; k++) begin
            if (j * G + k < L1N) begin
               l2_in[j] = l2_in[j] | l1_ff[j * G + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      l1_ff <= l1_in;
      l2_ff <= l2_in;
   end

   // last level stays small for the default depth: at most one fan-in group left
   always_comb begin
      root = '0;
      for (int j = 0; j < L2N; j++) begin
         root = root | l2_ff[j];
      end
   end

endmodule
